FILE: rtl/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

    localparam int DEF_PALETTE_ENTRIES = 259;
    localparam int DEF_CHANNEL_BITS    = 10;

    localparam int IDX_W     = 9;
    localparam int ERR_W     = 22;
    localparam int ALPHA_W   = 8;
    localparam int OUT_TDATA_W = 64;

    localparam logic [ERR_W-1:0]   ERR_MAX      = '1;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [IDX_W-1:0] IDX_ZERO        = 9'd0;
    localparam logic [IDX_W-1:0] IDX_LAST_BASIC  = 9'd15;
    localparam logic [IDX_W-1:0] IDX_FIRST_EXT   = 9'd16;
    localparam logic [IDX_W-1:0] IDX_TRANSPARENT = 9'd256;
    localparam logic [IDX_W-1:0] IDX_FG          = 9'd257;
    localparam logic [IDX_W-1:0] IDX_BG          = 9'd258;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PICK = 1'b1;

    localparam logic SPACE_RGB    = 1'b0;
    localparam logic SPACE_DIN99D = 1'b1;

    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_BASIC = 2'd2;
    localparam logic [1:0] MODE_FGBG  = 2'd3;

    localparam logic [1:0] CFG_COLOR_SPACE  = 2'd0;
    localparam logic [1:0] CFG_PALETTE_MODE = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } npc_state_t;

    // Per-entry control that travels alongside the distance pipeline.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             skip_if_bg;
    } npc_tag_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic [ERR_W-1:0] best_error;
        logic [IDX_W-1:0] second_index;
        logic [ERR_W-1:0] second_error;
        logic             have_second;
    } npc_result_t;

endpackage

FILE: rtl/npc_ram.sv
`timescale 1ns / 1ps

module npc_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 259
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/npc_dist.sv
`timescale 1ns / 1ps

module npc_dist
    import npc_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              metric_sel,
    input  logic                              in_valid,
    input  npc_tag_t                          in_tag,
    input  logic [3*CHANNEL_BITS+ALPHA_W-1:0] a_color,
    input  logic [3*CHANNEL_BITS+ALPHA_W-1:0] b_color,
    output logic                              out_valid,
    output npc_tag_t                          out_tag,
    output logic [ERR_W-1:0]                  out_err
);

    localparam int CB     = CHANNEL_BITS;
    localparam int DW     = CB + 1;
    localparam int SQW    = 2 * DW;
    localparam int PW     = CB + SQW;
    localparam int EW     = 3 * CB + 3;
    localparam int MW     = EW + 9;
    localparam int STAGES = 6;

    logic signed [CB-1:0] a0, a1, a2, b0, b1, b2;
    logic [ALPHA_W-1:0]   a3, b3;

    assign a0 = a_color[0 +: CB];
    assign a1 = a_color[CB +: CB];
    assign a2 = a_color[2*CB +: CB];
    assign a3 = a_color[3*CB +: ALPHA_W];
    assign b0 = b_color[0 +: CB];
    assign b1 = b_color[CB +: CB];
    assign b2 = b_color[2*CB +: CB];
    assign b3 = b_color[3*CB +: ALPHA_W];

    logic     vld_reg [STAGES];
    npc_tag_t tag_reg [STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < STAGES; i++) begin
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    // Stage 1: channel differences, half channel sum, alpha terms.
    logic signed [DW-1:0]      d0_next, d1_next, d2_next, ssum, sadj;
    logic signed [DW-1:0]      d0_reg, d1_reg, d2_reg;
    logic signed [CB-1:0]      sumh1_next, sumh1_reg;
    logic signed [ALPHA_W:0]   al1_next, al1_reg;
    logic [ALPHA_W-1:0]        mo1_next, mo1_reg;

    always_comb begin
        d0_next    = $signed({b0[CB-1], b0}) - $signed({a0[CB-1], a0});
        d1_next    = $signed({b1[CB-1], b1}) - $signed({a1[CB-1], a1});
        d2_next    = $signed({b2[CB-1], b2}) - $signed({a2[CB-1], a2});
        ssum       = $signed({a0[CB-1], a0}) + $signed({b0[CB-1], b0});
        sadj       = ssum + $signed({{(DW-1){1'b0}}, ssum[DW-1]});
        sumh1_next = sadj[DW-1:1];
        al1_next   = $signed({1'b0, b3}) - $signed({1'b0, a3});
        mo1_next   = (a3 > b3) ? a3 : b3;
    end

    always_ff @(posedge aclk) begin
        d0_reg    <= d0_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        sumh1_reg <= sumh1_next;
        al1_reg   <= al1_next;
        mo1_reg   <= mo1_next;
    end

    // Stage 2: squares.
    logic signed [SQW-1:0] sq0_next, sq1_next, sq2_next, sq0_reg, sq1_reg, sq2_reg;
    logic signed [17:0]    alsq2_next, alsq2_reg;
    logic signed [CB-1:0]  sumh2_reg;
    logic [ALPHA_W-1:0]    mo2_reg;

    always_comb begin
        sq0_next   = d0_reg * d0_reg;
        sq1_next   = d1_reg * d1_reg;
        sq2_next   = d2_reg * d2_reg;
        alsq2_next = al1_reg * al1_reg;
    end

    always_ff @(posedge aclk) begin
        sq0_reg   <= sq0_next;
        sq1_reg   <= sq1_next;
        sq2_reg   <= sq2_next;
        alsq2_reg <= alsq2_next;
        sumh2_reg <= sumh1_reg;
        mo2_reg   <= mo1_reg;
    end

    // Stage 3: red-weighted correction product and plain sums.
    logic signed [SQW-1:0] dsq, adiff;
    logic signed [EW-1:0]  s0e, s1e, s2e;
    logic signed [PW-1:0]  prod_next, prod_reg;
    logic signed [EW-1:0]  wsum_next, wsum_reg, euc_next, euc_reg;
    logic signed [17:0]    alsq3_reg;
    logic [ALPHA_W-1:0]    mo3_reg;

    always_comb begin
        dsq       = sq0_reg - sq2_reg;
        adiff     = dsq[SQW-1] ? -dsq : dsq;
        prod_next = sumh2_reg * adiff;
        s0e       = EW'(sq0_reg);
        s1e       = EW'(sq1_reg);
        s2e       = EW'(sq2_reg);
        wsum_next = (s0e <<< 1) + (s1e <<< 2) + s2e + (s2e <<< 1);
        euc_next  = s0e + s1e + s2e;
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        wsum_reg  <= wsum_next;
        euc_reg   <= euc_next;
        alsq3_reg <= alsq2_reg;
        mo3_reg   <= mo2_reg;
    end

    // Stage 4: color term, divisions truncate toward zero.
    logic signed [PW-1:0] padj, q;
    logic signed [EW-1:0] e_next, e_reg;
    logic signed [17:0]   alsq4_reg;
    logic [ALPHA_W-1:0]   mo4_reg;

    always_comb begin
        padj = prod_reg + $signed({{(PW-8){1'b0}}, {8{prod_reg[PW-1]}}});
        q    = padj >>> 8;
        if (metric_sel == SPACE_DIN99D) begin
            e_next = euc_reg;
        end else begin
            e_next = wsum_reg + EW'(q);
        end
    end

    always_ff @(posedge aclk) begin
        e_reg     <= e_next;
        alsq4_reg <= alsq3_reg;
        mo4_reg   <= mo3_reg;
    end

    // Stage 5: opacity scaling.
    logic signed [MW-1:0] m_next, m_reg;
    logic signed [17:0]   alsq5_reg;

    assign m_next = e_reg * $signed({1'b0, mo4_reg});

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        alsq5_reg <= alsq4_reg;
    end

    // Stage 6: alpha term and saturation.
    logic signed [MW-1:0] madj, t, f;
    logic [ERR_W-1:0]     err_next, err_reg;

    always_comb begin
        madj = m_reg + $signed({{(MW-8){1'b0}}, {8{m_reg[MW-1]}}});
        t    = madj >>> 8;
        f    = t + $signed(MW'({alsq5_reg, 3'b000}));
        if (f[MW-1]) begin
            err_next = '0;
        end else if (f > $signed(MW'(ERR_MAX))) begin
            err_next = ERR_MAX;
        end else begin
            err_next = f[ERR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        err_reg <= err_next;
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];
    assign out_err   = err_reg;

endmodule

FILE: rtl/npc_rank.sv
`timescale 1ns / 1ps

module npc_rank
    import npc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             in_valid,
    input  npc_tag_t         in_tag,
    input  logic [ERR_W-1:0] in_err,
    output npc_result_t      result
);

    logic             ok0_reg, ok0_next, ok1_reg, ok1_next;
    logic [IDX_W-1:0] idx0_reg, idx0_next, idx1_reg, idx1_next;
    logic [ERR_W-1:0] err0_reg, err0_next, err1_reg, err1_next;
    logic             take;

    always_comb begin
        ok0_next  = ok0_reg;
        ok1_next  = ok1_reg;
        idx0_next = idx0_reg;
        idx1_next = idx1_reg;
        err0_next = err0_reg;
        err1_next = err1_reg;
        // The opaque background is only tried when the background is not already best.
        take = in_valid && !(in_tag.skip_if_bg && ok0_reg && idx0_reg == IDX_BG);
        if (clear) begin
            ok0_next = 1'b0;
            ok1_next = 1'b0;
        end else if (take) begin
            if (!ok0_reg || in_err < err0_reg) begin
                ok1_next  = ok0_reg;
                idx1_next = idx0_reg;
                err1_next = err0_reg;
                ok0_next  = 1'b1;
                idx0_next = in_tag.idx;
                err0_next = in_err;
            end else if (!ok1_reg || in_err < err1_reg) begin
                ok1_next  = 1'b1;
                idx1_next = in_tag.idx;
                err1_next = in_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok0_reg <= 1'b0;
            ok1_reg <= 1'b0;
        end else begin
            ok0_reg <= ok0_next;
            ok1_reg <= ok1_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx0_reg <= idx0_next;
        idx1_reg <= idx1_next;
        err0_reg <= err0_next;
        err1_reg <= err1_next;
    end

    always_comb begin
        result.best_index   = ok0_reg ? idx0_reg : IDX_ZERO;
        result.best_error   = ok0_reg ? err0_reg : ERR_MAX;
        result.second_index = ok1_reg ? idx1_reg : IDX_ZERO;
        result.second_error = ok1_reg ? err1_reg : ERR_MAX;
        result.have_second  = ok1_reg;
    end

endmodule

FILE: rtl/nearest_palette_color_pick.sv
`timescale 1ns / 1ps

// Nearest palette color pick. A load transaction writes one palette entry and returns
// nothing. A pick transaction scans the entries chosen by palette_mode and returns the
// two closest entries with their saturated errors. A pick of N entries (257, 241, 17
// or 3 by mode) does one palette RAM read per cycle into a six-stage distance
// pipeline, followed by the ranking register and the output register. The input is
// ready again in the cycle after the result is loaded. The input is not ready while
// a pick is in progress, and a finished pick waits until the previous result has
// been taken.
module nearest_palette_color_pick
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int CHANNEL_BITS    = DEF_CHANNEL_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [1:0]                     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_index, chan_first, chan_second, chan_third, opacity, zero padding
    input  logic [((IDX_W+3*CHANNEL_BITS+ALPHA_W+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // best_index, best_error, second_index, second_error, zero padding
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata
);

    localparam int CB  = CHANNEL_BITS;
    localparam int CW  = 3 * CB + ALPHA_W;
    localparam int AW  = $clog2(PALETTE_ENTRIES);

    logic space_reg;
    logic [1:0] mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg <= SPACE_RGB;
            mode_reg  <= MODE_ALL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_COLOR_SPACE:  space_reg <= cfg_data[0];
                CFG_PALETTE_MODE: mode_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [IDX_W-1:0] in_index;
    logic [CW-1:0]    in_color;

    assign in_index = s_axis_tdata[IDX_W-1:0];
    assign in_color = s_axis_tdata[IDX_W +: CW];

    logic s_fire, pick_fire, ram_we;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign pick_fire = s_fire && (s_axis_tuser == ACT_PICK);
    assign ram_we    = s_fire && (s_axis_tuser == ACT_LOAD) &&
                       (int'(in_index) < PALETTE_ENTRIES);

    npc_state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             opq_reg, opq_next;
    logic [CW-1:0]    col_reg;
    logic             scan_last, issue, out_load;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic             dist_valid;
    npc_tag_t         dist_tag;
    logic [ERR_W-1:0] dist_err;
    npc_result_t      rank_res;

    assign scan_last = (mode_reg == MODE_FGBG) ? opq_reg : (idx_reg == IDX_TRANSPARENT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (pick_fire) state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: if (dist_valid && dist_tag.last) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SCAN:  issue = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  out_load = !m_valid_reg || m_axis_tready;
            default:  ;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        opq_next = opq_reg;
        if (pick_fire) begin
            opq_next = 1'b0;
            case (mode_reg)
                MODE_EXT:  idx_next = IDX_FIRST_EXT;
                MODE_FGBG: idx_next = IDX_FG;
                default:   idx_next = IDX_ZERO;
            endcase
        end else if (issue) begin
            case (mode_reg)
                MODE_FGBG: begin
                    if (idx_reg == IDX_FG) begin
                        idx_next = IDX_BG;
                    end else begin
                        opq_next = 1'b1;
                    end
                end
                MODE_BASIC: begin
                    idx_next = (idx_reg == IDX_LAST_BASIC) ? IDX_TRANSPARENT : idx_reg + 1'b1;
                end
                default: idx_next = idx_reg + 1'b1;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_TDATA_W'({rank_res.second_error, rank_res.second_index,
                                         rank_res.best_error, rank_res.best_index});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        opq_reg    <= opq_next;
        m_data_reg <= m_data_next;
        if (pick_fire) begin
            col_reg <= in_color;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Palette storage and the read stage that lines up with the registered RAM output.
    logic [CW-1:0] ram_rdata, b_color;
    logic          rd_valid_reg, rd_zero_reg, rd_opq_reg;
    npc_tag_t      rd_tag_reg;

    npc_ram #(
        .WIDTH (CW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_index)),
        .wdata (in_color),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        rd_zero_reg           <= !(int'(idx_reg) < PALETTE_ENTRIES);
        rd_opq_reg            <= opq_reg;
        rd_tag_reg.idx        <= idx_reg;
        rd_tag_reg.last       <= scan_last;
        rd_tag_reg.skip_if_bg <= opq_reg;
    end

    always_comb begin
        b_color = rd_zero_reg ? '0 : ram_rdata;
        if (rd_opq_reg) begin
            b_color[3*CB +: ALPHA_W] = ALPHA_OPAQUE;
        end
    end

    npc_dist #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .metric_sel  (space_reg),
        .in_valid    (rd_valid_reg),
        .in_tag      (rd_tag_reg),
        .a_color     (col_reg),
        .b_color     (b_color),
        .out_valid   (dist_valid),
        .out_tag     (dist_tag),
        .out_err     (dist_err)
    );

    npc_rank u_rank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (pick_fire),
        .in_valid (dist_valid),
        .in_tag   (dist_tag),
        .in_err   (dist_err),
        .result   (rank_res)
    );

`ifndef SYNTH
    a_dist_only_in_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance result outside of a pick");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished pick");

    a_second_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> rank_res.have_second)
        else $error("pick finished without a second candidate");
`endif

endmodule

FILE: dv/nearest_palette_color_pick_tb.sv
`timescale 1ns / 1ps

module nearest_palette_color_pick_tb;
    import npc_pkg::*;

    localparam int S_TDATA_W   = ((IDX_W + 3*DEF_CHANNEL_BITS + ALPHA_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS = 65;

    // Register indexes beyond the two implemented registers.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [ALPHA_W-1:0]                 opacity;
        logic signed [DEF_CHANNEL_BITS-1:0] chan_third;
        logic signed [DEF_CHANNEL_BITS-1:0] chan_second;
        logic signed [DEF_CHANNEL_BITS-1:0] chan_first;
    } pal_color_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic [ERR_W-1:0] best_error;
        logic [IDX_W-1:0] second_index;
        logic [ERR_W-1:0] second_error;
    } pick_result_t;

    class palette_pick_scoreboard;
        pal_color_t   pal_mem [DEF_PALETTE_ENTRIES];
        logic         space;
        logic [1:0]   mode;
        pick_result_t expected_picks [$];
        bit           rank_ok [2];
        logic [IDX_W-1:0] rank_idx [2];
        longint       rank_err [2];
        int           mismatches;
        int           picks_checked;
        int           loads_seen;
        int           reg_writes;

        function new();
            space = SPACE_RGB;
            mode = MODE_ALL;
            mismatches = 0;
            picks_checked = 0;
            loads_seen = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [1:0] data);
            reg_writes++;
            if (index == CFG_COLOR_SPACE) begin
                space = data[0];
            end else if (index == CFG_PALETTE_MODE) begin
                mode = data;
            end
        endfunction

        function longint color_error(pal_color_t a, pal_color_t b);
            longint a0, b0, d0, d1, d2, e, diff, al, mo;
            a0 = longint'($signed(a.chan_first));
            b0 = longint'($signed(b.chan_first));
            d0 = b0 - a0;
            d1 = longint'($signed(b.chan_second)) - longint'($signed(a.chan_second));
            d2 = longint'($signed(b.chan_third)) - longint'($signed(a.chan_third));
            d0 = d0 * d0;
            d1 = d1 * d1;
            d2 = d2 * d2;
            if (space == SPACE_RGB) begin
                diff = d0 - d2;
                if (diff < 0) begin
                    diff = -diff;
                end
                e = 2*d0 + 4*d1 + 3*d2 + (((a0 + b0) / 2) * diff) / 256;
            end else begin
                e = d0 + d1 + d2;
            end
            al = longint'(b.opacity) - longint'(a.opacity);
            al = al * al;
            mo = (a.opacity > b.opacity) ? longint'(a.opacity) : longint'(b.opacity);
            e = (e * mo) / 256 + al * 8;
            if (e < 0) begin
                e = 0;
            end
            if (e > longint'(ERR_MAX)) begin
                e = longint'(ERR_MAX);
            end
            return e;
        endfunction

        function void rank_entry(logic [IDX_W-1:0] idx, longint e);
            if (!rank_ok[0] || e < rank_err[0]) begin
                rank_ok[1] = rank_ok[0];
                rank_idx[1] = rank_idx[0];
                rank_err[1] = rank_err[0];
                rank_ok[0] = 1'b1;
                rank_idx[0] = idx;
                rank_err[0] = e;
            end else if (!rank_ok[1] || e < rank_err[1]) begin
                rank_ok[1] = 1'b1;
                rank_idx[1] = idx;
                rank_err[1] = e;
            end
        endfunction

        function pick_result_t nearest_pair(pal_color_t c);
            pick_result_t r;
            pal_color_t bg;
            rank_ok[0] = 1'b0;
            rank_ok[1] = 1'b0;
            rank_idx[0] = IDX_ZERO;
            rank_idx[1] = IDX_ZERO;
            rank_err[0] = 0;
            rank_err[1] = 0;
            case (mode)
                MODE_ALL: begin
                    for (int i = 0; i <= IDX_TRANSPARENT; i++) begin
                        rank_entry(IDX_W'(i), color_error(c, pal_mem[i]));
                    end
                end
                MODE_EXT: begin
                    for (int i = IDX_FIRST_EXT; i <= IDX_TRANSPARENT; i++) begin
                        rank_entry(IDX_W'(i), color_error(c, pal_mem[i]));
                    end
                end
                MODE_BASIC: begin
                    for (int i = 0; i <= IDX_LAST_BASIC; i++) begin
                        rank_entry(IDX_W'(i), color_error(c, pal_mem[i]));
                    end
                    rank_entry(IDX_TRANSPARENT, color_error(c, pal_mem[IDX_TRANSPARENT]));
                end
                default: begin
                    rank_entry(IDX_FG, color_error(c, pal_mem[IDX_FG]));
                    rank_entry(IDX_BG, color_error(c, pal_mem[IDX_BG]));
                    if (rank_idx[0] != IDX_BG) begin
                        bg = pal_mem[IDX_BG];
                        bg.opacity = ALPHA_OPAQUE;
                        rank_entry(IDX_BG, color_error(c, bg));
                    end
                end
            endcase
            r.best_index = rank_ok[0] ? rank_idx[0] : IDX_ZERO;
            r.best_error = rank_ok[0] ? ERR_W'(rank_err[0]) : ERR_MAX;
            r.second_index = rank_ok[1] ? rank_idx[1] : IDX_ZERO;
            r.second_error = rank_ok[1] ? ERR_W'(rank_err[1]) : ERR_MAX;
            return r;
        endfunction

        function void note_item(logic act, logic [S_TDATA_W-1:0] td);
            pal_color_t c;
            logic [IDX_W-1:0] idx;
            idx = td[8:0];
            c.chan_first = td[18:9];
            c.chan_second = td[28:19];
            c.chan_third = td[38:29];
            c.opacity = td[46:39];
            if (act == ACT_LOAD) begin
                loads_seen++;
                if (idx < DEF_PALETTE_ENTRIES) begin
                    pal_mem[idx] = c;
                end
            end else begin
                expected_picks.push_back(nearest_pair(c));
            end
        endfunction

        function void check_pick(logic [OUT_TDATA_W-1:0] td);
            pick_result_t exp_r;
            if (expected_picks.size() == 0) begin
                $error("pick result 0x%016h arrived with no pick outstanding", td);
                mismatches++;
                return;
            end
            exp_r = expected_picks.pop_front();
            picks_checked++;
            if (td[8:0] !== exp_r.best_index) begin
                $error("best_index: expected %0d, got %0d", exp_r.best_index, td[8:0]);
                mismatches++;
            end
            if (td[30:9] !== exp_r.best_error) begin
                $error("best_error: expected %0d, got %0d", exp_r.best_error, td[30:9]);
                mismatches++;
            end
            if (td[39:31] !== exp_r.second_index) begin
                $error("second_index: expected %0d, got %0d", exp_r.second_index, td[39:31]);
                mismatches++;
            end
            if (td[61:40] !== exp_r.second_error) begin
                $error("second_error: expected %0d, got %0d", exp_r.second_error, td[61:40]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [1:0]             cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    palette_pick_scoreboard sb;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit no_idle = 1'b0;

    nearest_palette_color_pick DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_pick(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tuser, s_axis_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
        end
        $display("nearest_palette_color_pick test failed");
        $finish;
    end

    initial begin
        int r;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(20, 100)) @(posedge aclk);
                end else if (r < 28) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 10)) @(posedge aclk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [DEF_CHANNEL_BITS-1:0] random_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return DEF_CHANNEL_BITS'(-512);
        end else if (r < 16) begin
            return DEF_CHANNEL_BITS'(511);
        end else if (r < 40) begin
            return DEF_CHANNEL_BITS'(int'($urandom_range(0, 4)) * 4 - 8);
        end
        return DEF_CHANNEL_BITS'($urandom);
    endfunction

    function automatic logic [ALPHA_W-1:0] random_opacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return ALPHA_OPAQUE;
        end else if (r < 30) begin
            return '0;
        end
        return ALPHA_W'($urandom);
    endfunction

    function automatic pal_color_t random_color();
        pal_color_t c;
        c.chan_first = random_channel();
        c.chan_second = random_channel();
        c.chan_third = random_channel();
        c.opacity = random_opacity();
        return c;
    endfunction

    function automatic pal_color_t make_color(int c1, int c2, int c3, int op);
        pal_color_t c;
        c.chan_first = DEF_CHANNEL_BITS'(c1);
        c.chan_second = DEF_CHANNEL_BITS'(c2);
        c.chan_third = DEF_CHANNEL_BITS'(c3);
        c.opacity = ALPHA_W'(op);
        return c;
    endfunction

    task automatic send_item(logic act, logic [IDX_W-1:0] idx, pal_color_t c);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {1'b0, c.opacity, c.chan_third, c.chan_second, c.chan_first, idx};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_config(logic space, logic [1:0] mode);
        wait_idle();
        write_reg(CFG_COLOR_SPACE, {1'b0, space});
        write_reg(CFG_PALETTE_MODE, mode);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        pal_color_t c;
        logic [IDX_W-1:0] idx;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                idx = IDX_W'($urandom_range(DEF_PALETTE_ENTRIES, 511));
            end else if (r < 30) begin
                idx = IDX_W'($urandom_range(IDX_TRANSPARENT, IDX_BG));
            end else begin
                idx = IDX_W'($urandom_range(0, DEF_PALETTE_ENTRIES - 1));
            end
            send_item(ACT_LOAD, idx, random_color());
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                c = sb.pal_mem[$urandom_range(0, DEF_PALETTE_ENTRIES - 1)];
                if ($urandom_range(0, 1) == 0) begin
                    c.opacity = random_opacity();
                end
            end else begin
                c = random_color();
            end
            send_item(ACT_PICK, IDX_W'($urandom_range(0, 511)), c);
        end
    endtask

    initial begin
        sb = new();
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= ACT_LOAD;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_config(SPACE_RGB, MODE_BASIC);
        // The basic colors and the transparent entry start at the far corner of the
        // color cube so that a pick from the opposite corner saturates every error.
        for (int i = 0; i < DEF_PALETTE_ENTRIES; i++) begin
            if (i <= IDX_LAST_BASIC || i == IDX_TRANSPARENT) begin
                send_item(ACT_LOAD, IDX_W'(i), make_color(-512, -512, -512, 255));
            end else begin
                send_item(ACT_LOAD, IDX_W'(i), random_color());
            end
        end

        send_item(ACT_PICK, IDX_ZERO, make_color(511, 511, 511, 255));
        send_item(ACT_PICK, 9'h1ff, make_color(-512, -512, -512, 255));
        send_item(ACT_PICK, IDX_ZERO, make_color(0, 0, 0, 0));

        apply_config(SPACE_RGB, MODE_ALL);
        send_item(ACT_LOAD, 9'd5, make_color(100, -50, 7, 200));
        send_item(ACT_LOAD, 9'd200, make_color(100, -50, 7, 200));
        send_item(ACT_LOAD, 9'h1ff, make_color(-1, -1, -1, 255));
        send_item(ACT_LOAD, 9'd259, make_color(0, 0, 0, 0));
        send_item(ACT_PICK, IDX_ZERO, make_color(100, -50, 7, 200));
        send_item(ACT_PICK, IDX_ZERO, make_color(511, -512, 511, 128));

        apply_config(SPACE_RGB, MODE_EXT);
        send_item(ACT_PICK, IDX_ZERO, make_color(100, -50, 7, 200));

        apply_config(SPACE_DIN99D, MODE_ALL);
        send_item(ACT_PICK, IDX_ZERO, make_color(511, 511, 511, 255));
        send_item(ACT_PICK, IDX_ZERO, make_color(-512, 511, -512, 1));

        apply_config(SPACE_RGB, MODE_FGBG);
        send_item(ACT_LOAD, IDX_FG, make_color(20, 20, 20, 255));
        send_item(ACT_LOAD, IDX_BG, make_color(0, 0, 0, 0));
        send_item(ACT_PICK, IDX_ZERO, make_color(0, 0, 0, 255));
        send_item(ACT_PICK, IDX_ZERO, make_color(0, 0, 0, 0));

        // Writes to unused indexes are dropped and wide values are masked.
        wait_idle();
        write_reg(CFG_SPARE_A, 2'b11);
        write_reg(CFG_SPARE_B, 2'b11);
        write_reg(CFG_COLOR_SPACE, 2'b10);
        write_reg(CFG_PALETTE_MODE, MODE_FGBG);
        cfg_valid <= 1'b0;
        send_item(ACT_PICK, IDX_ZERO, make_color(0, 0, 0, 255));

        for (int p = 0; p < 8; p++) begin
            apply_config(1'(p % 2), 2'(p / 2));
            no_idle = (p == 3);
            if (p == 6) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
        end
        no_idle = 1'b0;
        wait_idle();

        $display("Run covered %0d palette loads, %0d checked picks and %0d register writes",
                 sb.loads_seen, sb.picks_checked, sb.reg_writes);
        $display("across both color metrics and all four palette modes.");
        if (sb.mismatches == 0) begin
            $display("nearest_palette_color_pick test passed");
        end else begin
            $display("nearest_palette_color_pick test failed");
        end
        $finish;
    end

endmodule
